// ----- sv/sma_pkg.sv -----
// Shared constants and status types of the moving average filter.
package sma_pkg;

  localparam int CFG_W = 7;
  localparam int AVG_W = 24;
  localparam logic [CFG_W-1:0] LEN_RESET = 7'd4;

  typedef struct packed {
    logic busy;
  } front_status_t;

  typedef struct packed {
    logic busy;
  } back_status_t;

endpackage

// ----- sv/simple_moving_average.sv -----
// Top level of the simple moving average filter.
//
//  Channel   Handshake               Payload
//  input     push / full               sample_i
//  result    pop / empty               average_o
//  config    cfg_valid_i / cfg_ready_o  window_len_i
//
// A sample is written straight into the store while the window fills;
// afterwards the oldest sample is read from the store and then replaced.
// Each result is then formed in the serial divider; a two-entry queue lets
// samples arrive while it works. Reset sets the window length to four and
// empties the window; a length write restarts the stream. Either side may
// stall for any number of cycles.
module simple_moving_average import sma_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [AVG_W-1:0]       average_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_W-1:0]              window_len_i
);

  localparam int SumW = SAMPLE_BITS + $clog2(WINDOW_MAX);

  logic [CFG_W-1:0]       len_q, len_eff;
  logic                   cfg_write;
  logic                   q_push, q_full, q_pop, q_empty;
  logic signed [SumW-1:0] q_wsum, q_rsum;
  front_status_t          front_st;
  back_status_t           back_st;

  assign cfg_ready_o = ~front_st.busy & q_empty & ~back_st.busy & empty;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  always_comb begin
    if (len_q == '0) begin
      len_eff = CFG_W'(1);
    end else if (int'(len_q) > WINDOW_MAX) begin
      len_eff = CFG_W'(WINDOW_MAX);
    end else begin
      len_eff = len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_write) begin
      len_q <= window_len_i;
    end
  end

  sma_front #(
    .WindowMax  (WINDOW_MAX),
    .SampleBits (SAMPLE_BITS),
    .SumW       (SumW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .restart_i (cfg_write),
    .len_i     (len_eff),
    .push_i    (push),
    .full_o    (full),
    .sample_i  (sample_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_sum_o   (q_wsum),
    .status_o  (front_st)
  );

  sma_fifo #(
    .Width (SumW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flush_i (cfg_write),
    .push_i  (q_push),
    .wdata_i (q_wsum),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rsum),
    .empty_o (q_empty)
  );

  sma_back #(
    .SumW (SumW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .len_i     (len_eff),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .q_sum_i   (q_rsum),
    .empty_o   (empty),
    .pop_i     (pop),
    .average_o (average_o),
    .status_o  (back_st)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_st.busy |=> !front_st.busy)
    else $error("store update did not finish in one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |-> q_empty && !q_push)
    else $error("length written while sums were queued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(average_o))
    else $error("waiting result changed");

endmodule

// ----- sv/sma_ram.sv -----
// Generic single write port RAM with a registered read port.
module sma_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/sma_fifo.sv -----
// Two-entry queue of window sums between the front and back parts.
module sma_fifo #(
  parameter int Width = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             flush_i,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  logic [Width-1:0] data_q [2];
  logic             wr_q, wr_d, rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = data_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    if (flush_i) begin
      wr_d  = 1'b0;
      rd_d  = 1'b0;
      cnt_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ----- sv/sma_front.sv -----
// Front part: window store, running sum and the fill and slot counters.
module sma_front import sma_pkg::*; #(
  parameter int WindowMax  = 64,
  parameter int SampleBits = 16,
  parameter int SumW       = 22
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  logic [CFG_W-1:0]             len_i,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output logic signed [SumW-1:0]       q_sum_o,
  output front_status_t                status_o
);

  localparam int IdxW = $clog2(WindowMax);

  logic                         busy_q;
  logic signed [SumW-1:0]       sum_q, sum_d;
  logic [CFG_W-1:0]             fill_q, fill_d, slot_q, slot_d;
  logic signed [SampleBits-1:0] hold_q;
  logic                         accept, filling;
  logic                         we, re;
  logic [IdxW-1:0]              waddr;
  logic [SampleBits-1:0]        wdata, rdata;

  assign full_o   = busy_q | q_full_i;
  assign accept   = push_i & ~full_o;
  assign filling  = (fill_q < len_i);
  assign q_push_o = accept & ~filling;
  assign q_sum_o  = sum_q;
  assign status_o = '{busy: busy_q};

  assign we    = (accept & filling) | busy_q;
  assign waddr = busy_q ? IdxW'(slot_q) : IdxW'(fill_q);
  assign wdata = busy_q ? hold_q : sample_i;
  assign re    = accept & ~filling;

  sma_ram #(
    .Width (SampleBits),
    .Depth (WindowMax)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (IdxW'(slot_q)),
    .rdata_o (rdata)
  );

  always_comb begin
    sum_d  = sum_q;
    fill_d = fill_q;
    slot_d = slot_q;
    if (restart_i) begin
      sum_d  = '0;
      fill_d = '0;
      slot_d = '0;
    end else if (busy_q) begin
      sum_d  = sum_q - SumW'($signed(rdata)) + SumW'(hold_q);
      slot_d = (slot_q + 1'b1 == len_i) ? '0 : slot_q + 1'b1;
    end else if (accept && filling) begin
      sum_d  = sum_q + SumW'(sample_i);
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sum_q  <= '0;
      fill_q <= '0;
      slot_q <= '0;
    end else begin
      busy_q <= q_push_o & ~restart_i;
      sum_q  <= sum_d;
      fill_q <= fill_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= sample_i;
    end
  end

endmodule

// ----- sv/sma_back.sv -----
// Back part: bit-serial division of the window sum and the result register.
module sma_back import sma_pkg::*; #(
  parameter int SumW = 22
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [CFG_W-1:0]        len_i,
  input  logic                    q_empty_i,
  output logic                    q_pop_o,
  input  logic signed [SumW-1:0]  q_sum_i,
  output logic                    empty_o,
  input  logic                    pop_i,
  output logic signed [AVG_W-1:0] average_o,
  output back_status_t            status_o
);

  localparam int MagW = SumW + 8;
  localparam int CntW = $clog2(MagW);
  localparam int ResW = (MagW + 1 > AVG_W) ? MagW + 1 : AVG_W + 1;
  localparam logic signed [ResW-1:0] MaxV = ResW'(2 ** (AVG_W - 1) - 1);
  localparam logic signed [ResW-1:0] MinV = -MaxV - ResW'(1);

  typedef enum logic [1:0] {
    StIdle,
    StDiv,
    StDone
  } state_e;

  state_e                  state_q;
  logic                    neg_q, out_valid_q;
  logic [CFG_W-1:0]        rem_q;
  logic [MagW-1:0]         quo_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [AVG_W-1:0] avg_q;

  logic signed [SumW:0]    sum_ext, mag;
  logic [CFG_W:0]          trial;
  logic                    fits;
  logic signed [ResW-1:0]  res;
  logic signed [AVG_W-1:0] res_sat;

  assign sum_ext = (SumW + 1)'(q_sum_i);
  assign mag     = q_sum_i[SumW-1] ? -sum_ext : sum_ext;
  assign trial   = {rem_q, quo_q[MagW-1]};
  assign fits    = (trial >= {1'b0, len_i});

  always_comb begin
    res = neg_q ? -$signed(ResW'(quo_q)) : $signed(ResW'(quo_q));
    if (res > MaxV) begin
      res_sat = AVG_W'(MaxV);
    end else if (res < MinV) begin
      res_sat = AVG_W'(MinV);
    end else begin
      res_sat = AVG_W'(res);
    end
  end

  assign q_pop_o   = (state_q == StIdle) & ~q_empty_i;
  assign empty_o   = ~out_valid_q;
  assign average_o = avg_q;
  assign status_o  = '{busy: (state_q != StIdle)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
      neg_q       <= 1'b0;
      rem_q       <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      avg_q       <= '0;
    end else begin
      if (pop_i && out_valid_q && (state_q != StDone)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (!q_empty_i) begin
            neg_q   <= q_sum_i[SumW-1];
            rem_q   <= '0;
            quo_q   <= {mag[SumW-1:0], 8'b0};
            cnt_q   <= '0;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          rem_q <= fits ? CFG_W'(trial - {1'b0, len_i}) : CFG_W'(trial);
          quo_q <= {quo_q[MagW-2:0], fits};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(MagW - 1)) begin
            state_q <= StDone;
          end
        end
        StDone: begin
          if (!out_valid_q || pop_i) begin
            avg_q       <= res_sat;
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
